[rtl/core/ttb_pkg.sv]
// Shared types and constants of the triangle tile binner.
package ttb_pkg;

  localparam int DEF_GRID_COLUMNS = 8;
  localparam int DEF_GRID_ROWS    = 8;
  localparam int MAX_PAIRS        = 64;

  localparam int COORD_W    = 16;
  localparam int TRI_W      = 16;
  localparam int TILE_IDX_W = 6;
  localparam int BINNED_W   = 16;
  localparam int TOUCHED_W  = 7;
  localparam int LOG2_W     = 4;
  localparam int SHIFT_W    = 5;
  localparam int FRAC_W     = 4;
  localparam int GRID_POS_W = 6;
  localparam int PAIR_CNT_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam int IN_TDATA_W  = TRI_W + 6 * COORD_W;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_USED_W  = TILE_IDX_W + TRI_W + BINNED_W + TOUCHED_W;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam logic [LOG2_W-1:0] TILE_LOG2_RESET = 4'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT_LOG2 = 2'd1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                  empty;
    logic [GRID_POS_W-1:0] col_lo;
    logic [GRID_POS_W-1:0] col_hi;
    logic [GRID_POS_W-1:0] row_lo;
    logic [GRID_POS_W-1:0] row_hi;
  } bbox_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_WALK
  } state_e;

endpackage

[rtl/core/ttb_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module ttb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ttb_bbox.sv]
// Tile bounding box unit: vertex min/max, tile shifts and clamping to the grid.
module ttb_bbox import ttb_pkg::*; #(
  parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = DEF_GRID_ROWS
) (
  input  logic              clk_i,
  input  logic              load_i,
  input  coord_t            vert_x_i [3],
  input  coord_t            vert_y_i [3],
  input  logic              update_i,
  input  logic [LOG2_W-1:0] tile_width_log2_i,
  input  logic [LOG2_W-1:0] tile_height_log2_i,
  output bbox_t             bbox_o
);

  localparam logic signed [COORD_W:0] COL_LAST = (COORD_W + 1)'(GRID_COLUMNS - 1);
  localparam logic signed [COORD_W:0] ROW_LAST = (COORD_W + 1)'(GRID_ROWS - 1);

  coord_t min_x_q, max_x_q, min_y_q, max_y_q;
  bbox_t  bbox_q;

  logic [SHIFT_W-1:0]      shift_x, shift_y;
  logic signed [COORD_W:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [COORD_W:0] x_lo_c, x_hi_c, y_lo_c, y_hi_c;

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // First tile: floor(v / 2^s), an arithmetic shift.
  function automatic logic signed [COORD_W:0] tile_floor(coord_t v, logic [SHIFT_W-1:0] s);
    logic signed [COORD_W:0] ext;
    ext = {v[COORD_W-1], v};
    return ext >>> s;
  endfunction

  // Last tile: ceil(v / 2^s) - 1, which equals floor((v - 1) / 2^s).
  function automatic logic signed [COORD_W:0] tile_last(coord_t v, logic [SHIFT_W-1:0] s);
    logic signed [COORD_W:0] ext;
    ext = {v[COORD_W-1], v} - (COORD_W + 1)'(1);
    return ext >>> s;
  endfunction

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      min_x_q <= min3(vert_x_i[0], vert_x_i[1], vert_x_i[2]);
      max_x_q <= max3(vert_x_i[0], vert_x_i[1], vert_x_i[2]);
      min_y_q <= min3(vert_y_i[0], vert_y_i[1], vert_y_i[2]);
      max_y_q <= max3(vert_y_i[0], vert_y_i[1], vert_y_i[2]);
    end
  end

  always_comb begin
    shift_x = SHIFT_W'(tile_width_log2_i) + SHIFT_W'(FRAC_W);
    shift_y = SHIFT_W'(tile_height_log2_i) + SHIFT_W'(FRAC_W);
    x_lo    = tile_floor(min_x_q, shift_x);
    x_hi    = tile_last(max_x_q, shift_x);
    y_lo    = tile_floor(min_y_q, shift_y);
    y_hi    = tile_last(max_y_q, shift_y);
    x_lo_c  = x_lo[COORD_W] ? '0 : x_lo;
    y_lo_c  = y_lo[COORD_W] ? '0 : y_lo;
    x_hi_c  = (x_hi > COL_LAST) ? COL_LAST : x_hi;
    y_hi_c  = (y_hi > ROW_LAST) ? ROW_LAST : y_hi;
  end

  always_ff @(posedge clk_i) begin
    if (update_i) begin
      bbox_q.empty  <= (x_lo_c > x_hi_c) || (y_lo_c > y_hi_c);
      bbox_q.col_lo <= x_lo_c[GRID_POS_W-1:0];
      bbox_q.col_hi <= x_hi_c[GRID_POS_W-1:0];
      bbox_q.row_lo <= y_lo_c[GRID_POS_W-1:0];
      bbox_q.row_hi <= y_hi_c[GRID_POS_W-1:0];
    end
  end

  assign bbox_o = bbox_q;

endmodule

[rtl/core/triangle_tile_binner.sv]
// Triangle tile binner top level: control, tile walk, occupancy map and counters.
// Flow: an accepted item has its box set up in ST_SETUP, then its walk starts in ST_START.
// Throughput: one tile pair per cycle from the occupancy RAM read port while the output is
// not stalled; culled items and empty boxes give no pairs.
// A batch start adds a sweep over all GRID_COLUMNS * GRID_ROWS entries that clears the map.
// Reset: the same sweep runs after reset before the first item; both tile sizes reset to 5.
module triangle_tile_binner import ttb_pkg::*; #(
  parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = DEF_GRID_ROWS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Fields from bit 0: triangle_index, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
  // vertex2_x, vertex2_y.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: culled, batch_start.
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: tile_index, binned_triangle, triangle count, touched tile count.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [LOG2_W-1:0]      cfg_data_i
);

  localparam int TILE_COUNT = GRID_COLUMNS * GRID_ROWS;
  localparam int TILE_AW    = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam logic [TILE_AW-1:0]    LAST_TILE_ADDR = TILE_AW'(TILE_COUNT - 1);
  localparam logic [PAIR_CNT_W-1:0] LAST_PAIR      = PAIR_CNT_W'(MAX_PAIRS - 1);

  state_e state_q, state_d;

  logic [LOG2_W-1:0] tile_w_q, tile_h_q;
  logic [TRI_W-1:0]  tri_q;
  logic              culled_q;
  logic              item_pending_q;

  logic s_accept, in_culled, in_batch;
  logic clearing, bbox_update, walk_start, walk_issue, walk_last;

  coord_t vert_x [3];
  coord_t vert_y [3];
  bbox_t  bbox;

  logic [TILE_AW-1:0]    clr_q;
  logic [GRID_POS_W-1:0] col_q, row_q;
  logic [PAIR_CNT_W-1:0] n_q;
  logic [TILE_AW-1:0]    walk_addr;

  logic               s2_valid_q, s2_last_q, s2_fire, s2_stall;
  logic [TILE_AW-1:0] s2_addr_q;
  logic               out_free;

  logic               ram_we, ram_wdata, occupied;
  logic [TILE_AW-1:0] ram_waddr, ram_raddr;

  logic [BINNED_W-1:0]   binned_q;
  logic [TOUCHED_W-1:0]  touched_q, touched_next;
  logic                  touched_hit;

  logic                  out_valid_q, out_last_q;
  logic [TILE_IDX_W-1:0] out_tile_q;
  logic [TRI_W-1:0]      out_tri_q;
  logic [BINNED_W-1:0]   out_binned_q;
  logic [TOUCHED_W-1:0]  out_touched_q;

  assign in_culled     = s_axis_tuser[0];
  assign in_batch      = s_axis_tuser[1];
  assign s_axis_tready = (state_q == ST_IDLE) && !s2_valid_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vert_x[k] = coord_t'(s_axis_tdata[TRI_W + 2 * k * COORD_W +: COORD_W]);
      vert_y[k] = coord_t'(s_axis_tdata[TRI_W + (2 * k + 1) * COORD_W +: COORD_W]);
    end
  end

  ttb_bbox #(
    .GRID_COLUMNS(GRID_COLUMNS),
    .GRID_ROWS   (GRID_ROWS)
  ) u_bbox (
    .clk_i             (clk_i),
    .load_i            (s_accept),
    .vert_x_i          (vert_x),
    .vert_y_i          (vert_y),
    .update_i          (bbox_update),
    .tile_width_log2_i (tile_w_q),
    .tile_height_log2_i(tile_h_q),
    .bbox_o            (bbox)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_w_q <= TILE_LOG2_RESET;
      tile_h_q <= TILE_LOG2_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TILE_WIDTH_LOG2:  tile_w_q <= cfg_data_i;
        CFG_TILE_HEIGHT_LOG2: tile_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tile walk: row-major over the clamped box.
  assign walk_addr = TILE_AW'(int'(row_q) * GRID_COLUMNS + int'(col_q));
  assign walk_last = ((row_q == bbox.row_hi) && (col_q == bbox.col_hi)) || (n_q == LAST_PAIR);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_TILE_ADDR) begin
          state_d = (item_pending_q && !culled_q) ? ST_SETUP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          if (in_batch) begin
            state_d = ST_CLEAR;
          end else if (!in_culled) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: state_d = ST_START;
      ST_START: state_d = bbox.empty ? ST_IDLE : ST_WALK;
      ST_WALK: begin
        if (walk_issue && walk_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clearing    = 1'b0;
    bbox_update = 1'b0;
    walk_start  = 1'b0;
    walk_issue  = 1'b0;
    case (state_q)
      ST_CLEAR: clearing    = 1'b1;
      ST_SETUP: bbox_update = 1'b1;
      ST_START: walk_start  = !bbox.empty;
      ST_WALK:  walk_issue  = !s2_valid_q || s2_fire;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      item_pending_q <= 1'b0;
      culled_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clearing ? clr_q + TILE_AW'(1) : '0;
      if (s_accept) begin
        item_pending_q <= 1'b1;
        culled_q       <= in_culled;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      tri_q <= s_axis_tdata[TRI_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      n_q   <= '0;
    end else if (walk_start) begin
      col_q <= bbox.col_lo;
      row_q <= bbox.row_lo;
      n_q   <= '0;
    end else if (walk_issue) begin
      n_q <= n_q + PAIR_CNT_W'(1);
      if (col_q == bbox.col_hi) begin
        col_q <= bbox.col_lo;
        row_q <= row_q + GRID_POS_W'(1);
      end else begin
        col_q <= col_q + GRID_POS_W'(1);
      end
    end
  end

  // Read stage: the map bit arrives in the cycle after the address. While the output
  // is stalled the same address is read again, so the data stays current.
  assign out_free = !out_valid_q || m_axis_tready;
  assign s2_fire  = s2_valid_q && out_free;
  assign s2_stall = s2_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (walk_issue) begin
      s2_valid_q <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_issue) begin
      s2_addr_q <= walk_addr;
      s2_last_q <= walk_last;
    end
  end

  // A new item is only taken once the last pair has written the map, so reads and
  // writes of one entry never overlap.
  assign ram_we    = clearing || s2_fire;
  assign ram_waddr = clearing ? clr_q : s2_addr_q;
  assign ram_wdata = !clearing;
  assign ram_raddr = s2_stall ? s2_addr_q : walk_addr;

  ttb_ram #(
    .WIDTH(1),
    .DEPTH(TILE_COUNT)
  ) u_occupancy (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(occupied)
  );

  // Batch counters, both saturating.
  assign touched_hit  = s2_fire && !occupied && (touched_q != '1);
  assign touched_next = touched_q + TOUCHED_W'(touched_hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binned_q  <= '0;
      touched_q <= '0;
    end else if (s_accept && in_batch) begin
      binned_q  <= '0;
      touched_q <= '0;
    end else begin
      touched_q <= touched_next;
      if (walk_start && (binned_q != '1)) begin
        binned_q <= binned_q + BINNED_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_tile_q    <= TILE_IDX_W'(s2_addr_q);
      out_tri_q     <= tri_q;
      out_last_q    <= s2_last_q;
      out_binned_q  <= binned_q;
      out_touched_q <= touched_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_touched_q, out_binned_q, out_tri_q, out_tile_q};

  // A new read never targets the entry that is being written back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk_issue && s2_fire) |-> (walk_addr != s2_addr_q))
    else $error("occupancy read and write collide on one entry");

  // Once the last pair of a triangle leaves the read stage, the walk is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s2_last_q) |-> (state_q != ST_WALK))
    else $error("tile walk still running after its last pair");

  // The clearing sweep never runs alongside a pending map access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!s2_valid_q && !walk_issue))
    else $error("map access during clearing sweep");

  // The touched-tile count changes only when a pair goes out or a batch starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s2_fire && !s_accept) |=> $stable(touched_q))
    else $error("touched-tile count changed without a pair");

endmodule
